// ===== rtl/cfm_pkg.sv =====
// Shared types and constants for the capture frequency meter.
package cfm_pkg;

	localparam int unsigned TS_W     = 16;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned RATE_W   = 24;
	localparam int unsigned FREQ_W   = 24;

	localparam logic [RATE_W-1:0] CLOCK_RATE_RESET = 24'd1070000;

	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_ARM     = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} cfm_state_t;

endpackage

// ===== rtl/capture_frequency_meter_unit.sv =====
// Capture frequency meter: two timer stamps give a period and clock_rate / period.
// An arm request or a capture that yields no result is taken without a stall. The second
// capture after arming computes the period at once and then runs a bit-serial divider
// that produces one quotient bit per cycle over the 24-bit clock rate; when it is done
// the result shows on the output, and the input stays stalled until the result is
// taken. A zero period skips the divider and shows a frequency of 0 the cycle after
// acceptance. Captures after the result are ignored until the next arm request.
module capture_frequency_meter_unit import cfm_pkg::*; #(
	parameter int unsigned STAMP_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [TS_W-1:0]     timestamp,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PERIOD_W-1:0] period_ticks,
	output logic [FREQ_W-1:0]   frequency,
	input  logic                cfg_wr_en,
	input  logic [RATE_W-1:0]   cfg_wr_data
);

	localparam int unsigned IN_W = (STAMP_WIDTH < TS_W) ? STAMP_WIDTH : TS_W;

	cfm_state_t state_q, state_d;

	logic [RATE_W-1:0]      clock_rate_q;
	logic                   have_first_q;
	logic                   done_q;
	logic [STAMP_WIDTH-1:0] first_stamp_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [FREQ_W-1:0]      freq_q;

	logic [STAMP_WIDTH-1:0] stamp;
	logic [STAMP_WIDTH-1:0] period;
	logic                   accept;
	logic                   is_result;
	logic                   div_start;
	logic                   div_done;
	logic [FREQ_W-1:0]      div_quotient;

	assign stamp     = STAMP_WIDTH'(timestamp[IN_W-1:0]);
	assign period    = stamp - first_stamp_q;
	assign accept    = in_valid && !in_stall;
	assign is_result = accept && (opcode == OP_CAPTURE) && !done_q && have_first_q;
	assign div_start = is_result && (period != '0);

	cfm_div #(
		.DIVISOR_W (STAMP_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clock_rate_q),
		.divisor  (period),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			clock_rate_q <= CLOCK_RATE_RESET;
			have_first_q <= 1'b0;
			done_q       <= 1'b0;
			first_stamp_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				clock_rate_q <= cfg_wr_data;
			end
			if (accept) begin
				if (opcode == OP_ARM) begin
					have_first_q <= 1'b0;
					done_q       <= 1'b0;
				end else if (!done_q) begin
					if (!have_first_q) begin
						first_stamp_q <= stamp;
						have_first_q  <= 1'b1;
					end else begin
						have_first_q <= 1'b0;
						done_q       <= 1'b1;
					end
				end
			end
		end
	end

	// Result payload: period at acceptance, frequency cleared then and loaded when the divider finishes.
	always_ff @(posedge clk) begin
		if (is_result) begin
			period_q <= PERIOD_W'(period);
			freq_q   <= '0;
		end else if (div_done) begin
			freq_q <= div_quotient;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (div_start) begin
					state_d = ST_DIV;
				end else if (is_result) begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = (state_q == ST_OUT);
	assign period_ticks = period_q;
	assign frequency    = freq_q;

endmodule

// ===== rtl/cfm_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle over the clock-rate width.
module cfm_div import cfm_pkg::*; #(
	parameter int unsigned DIVISOR_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RATE_W-1:0]    dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [FREQ_W-1:0]    quotient
);

	localparam int unsigned CNT_W = $clog2(RATE_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RATE_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [RATE_W-1:0]    quo_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder, then try a subtract.
	assign trial = {rem_q, quo_q[RATE_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			divisor_q <= divisor;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[RATE_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = FREQ_W'(quo_q);

endmodule
